// ----- hdl/binary_min_heap_queue_core_defines.svh -----
// Assertion macros for the heap queue RTL.
`ifndef BINARY_MIN_HEAP_QUEUE_CORE_DEFINES_SVH
`define BINARY_MIN_HEAP_QUEUE_CORE_DEFINES_SVH

`ifndef ASSERT_OFF
`define BMHQ_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("heap queue check failed");
`define BMHQ_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("heap queue check failed");
`else
`define BMHQ_ASSERT_IMP(lbl, ante, cons)
`define BMHQ_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

// ----- hdl/bmhq_pkg.sv -----
`timescale 1ns / 1ps
package bmhq_pkg;

  localparam int HeapCapacity = 127;
  localparam int KeyW         = 16;
  localparam int PayloadW     = 16;
  localparam int EntryW       = KeyW + PayloadW;
  localparam int CountW       = 7;
  localparam int ModeW        = 2;
  localparam int StatusW      = 2;
  localparam int InDataW      = 32;
  localparam int OutDataW     = 40;

  localparam logic [ModeW-1:0] MODE_INSERT = 2'd0;
  localparam logic [ModeW-1:0] MODE_REMOVE = 2'd1;
  localparam logic [ModeW-1:0] MODE_CLEAR  = 2'd2;

  localparam logic [StatusW-1:0] ST_OK    = 2'd0;
  localparam logic [StatusW-1:0] ST_FULL  = 2'd1;
  localparam logic [StatusW-1:0] ST_EMPTY = 2'd2;

  typedef enum logic [3:0] {
    S_IDLE,
    S_INS_START,
    S_INS_CMP,
    S_INS_FIN,
    S_DEL_ROOT,
    S_DEL_LAST,
    S_DEL_INIT,
    S_DEL_CHK,
    S_DEL_RL,
    S_DEL_RR,
    S_DEL_CMP,
    S_DEL_FIN,
    S_DONE
  } state_t;

  typedef enum logic [2:0] {
    RD_ONE,
    RD_FILL,
    RD_UP,
    RD_GRAND,
    RD_LEFT,
    RD_RIGHT,
    RD_PICKL
  } rd_sel_t;

  typedef enum logic [1:0] {
    WD_ENTRY,
    WD_RDATA,
    WD_CHILD
  } wd_sel_t;

  typedef enum logic [2:0] {
    POS_HOLD,
    POS_INS,
    POS_ONE,
    POS_UP,
    POS_PICK
  } pos_sel_t;

  typedef struct packed {
    logic                res_set;
    logic [StatusW-1:0]  res_status;
    logic                res_root;
    logic                ins_load;
    logic                fill_clr;
    logic                cap_root;
    logic                cap_last;
    logic                cap_left;
    logic                cap_right;
    rd_sel_t             rd_sel;
    logic                wr_en;
    wd_sel_t             wd_sel;
    pos_sel_t            pos_sel;
    logic                out_load;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
    logic pos_gt1;
    logic up_gt1;
    logic new_lt_rd;
    logic left_gt_size;
    logic left_lt_size;
    logic last_le_child;
    logic pickl_gt_size;
    logic out_free;
  } sts_t;

endpackage

// ----- hdl/bmhq_ram.sv -----
`timescale 1ns / 1ps
module bmhq_ram #(
  parameter int Width = 32,
  parameter int Depth = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ----- hdl/bmhq_ctrl.sv -----
`timescale 1ns / 1ps
module bmhq_ctrl (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_tvalid,
  input  logic [bmhq_pkg::ModeW-1:0]   in_mode,
  output logic                         in_tready,
  input  bmhq_pkg::sts_t               sts,
  output bmhq_pkg::cmd_t               cmd
);
  import bmhq_pkg::*;

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          if (in_mode == MODE_INSERT && !sts.full) begin
            state_nxt = S_INS_START;
          end else if (in_mode == MODE_REMOVE && !sts.empty) begin
            state_nxt = S_DEL_ROOT;
          end else begin
            state_nxt = S_DONE;
          end
        end
      end
      S_INS_START: state_nxt = sts.pos_gt1 ? S_INS_CMP : S_DONE;
      S_INS_CMP: begin
        if (!sts.new_lt_rd) begin
          state_nxt = S_DONE;
        end else if (!sts.up_gt1) begin
          state_nxt = S_INS_FIN;
        end
      end
      S_INS_FIN:  state_nxt = S_DONE;
      S_DEL_ROOT: state_nxt = S_DEL_LAST;
      S_DEL_LAST: state_nxt = S_DEL_INIT;
      S_DEL_INIT: state_nxt = S_DEL_CHK;
      S_DEL_CHK:  state_nxt = sts.left_gt_size ? S_DONE : S_DEL_RL;
      S_DEL_RL:   state_nxt = sts.left_lt_size ? S_DEL_RR : S_DEL_CMP;
      S_DEL_RR:   state_nxt = S_DEL_CMP;
      S_DEL_CMP: begin
        if (sts.last_le_child) begin
          state_nxt = S_DONE;
        end else if (sts.pickl_gt_size) begin
          state_nxt = S_DEL_FIN;
        end else begin
          state_nxt = S_DEL_RL;
        end
      end
      S_DEL_FIN:  state_nxt = S_DONE;
      S_DONE:     state_nxt = sts.out_free ? S_IDLE : S_DONE;
      default:    state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd        = '0;
    cmd.rd_sel = RD_ONE;
    cmd.wd_sel = WD_ENTRY;
    cmd.pos_sel = POS_HOLD;
    in_tready  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.res_set = 1'b1;
          if (in_mode == MODE_INSERT) begin
            if (sts.full) begin
              cmd.res_status = ST_FULL;
            end else begin
              cmd.ins_load = 1'b1;
              cmd.pos_sel  = POS_INS;
            end
          end else if (in_mode == MODE_REMOVE) begin
            if (sts.empty) begin
              cmd.res_status = ST_EMPTY;
            end else begin
              cmd.res_root = 1'b1;
            end
          end else if (in_mode == MODE_CLEAR) begin
            cmd.fill_clr = 1'b1;
          end
        end
      end
      S_INS_START: begin
        if (sts.pos_gt1) begin
          cmd.rd_sel = RD_UP;
        end else begin
          cmd.wr_en = 1'b1;
        end
      end
      S_INS_CMP: begin
        cmd.wr_en = 1'b1;
        if (sts.new_lt_rd) begin
          cmd.wd_sel  = WD_RDATA;
          cmd.pos_sel = POS_UP;
          cmd.rd_sel  = RD_GRAND;
        end
      end
      S_INS_FIN: cmd.wr_en = 1'b1;
      S_DEL_ROOT: cmd.rd_sel = RD_ONE;
      S_DEL_LAST: begin
        cmd.cap_root = 1'b1;
        cmd.rd_sel   = RD_FILL;
      end
      S_DEL_INIT: begin
        cmd.cap_last = 1'b1;
        cmd.pos_sel  = POS_ONE;
      end
      S_DEL_CHK: begin
        if (sts.left_gt_size) begin
          cmd.wr_en = 1'b1;
        end else begin
          cmd.rd_sel = RD_LEFT;
        end
      end
      S_DEL_RL: begin
        cmd.cap_left = 1'b1;
        cmd.rd_sel   = RD_RIGHT;
      end
      S_DEL_RR: cmd.cap_right = 1'b1;
      S_DEL_CMP: begin
        cmd.wr_en = 1'b1;
        if (!sts.last_le_child) begin
          cmd.wd_sel  = WD_CHILD;
          cmd.pos_sel = POS_PICK;
          cmd.rd_sel  = RD_PICKL;
        end
      end
      S_DEL_FIN: cmd.wr_en = 1'b1;
      S_DONE: cmd.out_load = sts.out_free;
      default: cmd = '0;
    endcase
  end

endmodule

// ----- hdl/bmhq_dpath.sv -----
`timescale 1ns / 1ps
module bmhq_dpath #(
  parameter int CAPACITY = bmhq_pkg::HeapCapacity
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  bmhq_pkg::cmd_t                  cmd,
  output bmhq_pkg::sts_t                  sts,
  input  logic [bmhq_pkg::InDataW-1:0]    in_tdata,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [bmhq_pkg::OutDataW-1:0]   out_tdata,
  output logic [bmhq_pkg::StatusW-1:0]    out_tuser
);
  import bmhq_pkg::*;

  localparam int Depth = CAPACITY + 1;
  localparam int AW    = $clog2(Depth);

  logic [AW-1:0]      fill_r, fill_nxt;
  logic [AW-1:0]      pos_r, pos_nxt;
  logic [AW-1:0]      pick_r;
  logic [EntryW-1:0]  entry_r, root_r, child_r;
  logic [StatusW-1:0] res_status_r;
  logic               res_root_r;
  logic               out_valid_r, out_valid_nxt;
  logic [OutDataW-1:0] out_data_r;
  logic [StatusW-1:0] out_user_r;

  logic [AW:0]        left, right, pickl;
  logic [AW-1:0]      up;
  logic [AW-1:0]      raddr;
  logic [EntryW-1:0]  wdata, rdata;
  logic [KeyW-1:0]    res_key, res_payload;

  assign left  = {pos_r, 1'b0};
  assign right = left + 1'b1;
  assign pickl = {pick_r, 1'b0};
  assign up    = pos_r >> 1;

  always_comb begin
    unique case (cmd.rd_sel)
      RD_ONE:   raddr = AW'(1);
      RD_FILL:  raddr = fill_r;
      RD_UP:    raddr = up;
      RD_GRAND: raddr = pos_r >> 2;
      RD_LEFT:  raddr = left[AW-1:0];
      RD_RIGHT: raddr = right[AW-1:0];
      RD_PICKL: raddr = pickl[AW-1:0];
      default:  raddr = AW'(1);
    endcase
  end

  always_comb begin
    unique case (cmd.wd_sel)
      WD_ENTRY: wdata = entry_r;
      WD_RDATA: wdata = rdata;
      WD_CHILD: wdata = child_r;
      default:  wdata = entry_r;
    endcase
  end

  bmhq_ram #(
    .Width (EntryW),
    .Depth (Depth)
  ) u_heap (
    .clk   (clk),
    .we    (cmd.wr_en),
    .waddr (pos_r),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_comb begin
    unique case (cmd.pos_sel)
      POS_HOLD: pos_nxt = pos_r;
      POS_INS:  pos_nxt = fill_r + 1'b1;
      POS_ONE:  pos_nxt = AW'(1);
      POS_UP:   pos_nxt = up;
      POS_PICK: pos_nxt = pick_r;
      default:  pos_nxt = pos_r;
    endcase
  end

  always_comb begin
    priority if (cmd.fill_clr) begin
      fill_nxt = '0;
    end else if (cmd.ins_load) begin
      fill_nxt = fill_r + 1'b1;
    end else if (cmd.cap_last) begin
      fill_nxt = fill_r - 1'b1;
    end else begin
      fill_nxt = fill_r;
    end
  end

  always_comb begin
    priority if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      fill_r      <= fill_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign res_key     = res_root_r ? root_r[EntryW-1:PayloadW] : '0;
  assign res_payload = res_root_r ? root_r[PayloadW-1:0] : '0;

  always_ff @(posedge clk) begin
    pos_r <= pos_nxt;
    if (cmd.res_set) begin
      res_status_r <= cmd.res_status;
      res_root_r   <= cmd.res_root;
    end
    if (cmd.ins_load) begin
      entry_r <= {in_tdata[KeyW-1:0], in_tdata[InDataW-1:KeyW]};
    end else if (cmd.cap_last) begin
      entry_r <= rdata;
    end
    if (cmd.cap_root) begin
      root_r <= rdata;
    end
    if (cmd.cap_left) begin
      child_r <= rdata;
      pick_r  <= left[AW-1:0];
    end else if (cmd.cap_right
                 && child_r[EntryW-1:PayloadW] > rdata[EntryW-1:PayloadW]) begin
      child_r <= rdata;
      pick_r  <= right[AW-1:0];
    end
    if (cmd.out_load) begin
      out_data_r <= {1'b0, CountW'(fill_r), res_payload, res_key};
      out_user_r <= res_status_r;
    end
  end

  always_comb begin
    sts.full          = (fill_r == AW'(CAPACITY));
    sts.empty         = (fill_r == '0);
    sts.pos_gt1       = (pos_r > AW'(1));
    sts.up_gt1        = (up > AW'(1));
    sts.new_lt_rd     = (entry_r[EntryW-1:PayloadW] < rdata[EntryW-1:PayloadW]);
    sts.left_gt_size  = (left > {1'b0, fill_r});
    sts.left_lt_size  = (left < {1'b0, fill_r});
    sts.last_le_child = (entry_r[EntryW-1:PayloadW] <= child_r[EntryW-1:PayloadW]);
    sts.pickl_gt_size = (pickl > {1'b0, fill_r});
    sts.out_free      = !out_valid_r || out_tready;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

endmodule

// ----- hdl/binary_min_heap_queue_core.sv -----
// Binary min-heap priority queue of 16-bit key / 16-bit payload pairs, up to
// CAPACITY pairs held in one RAM with a registered read port. Each beat on the
// input is an insert, a remove-min, a clear or a no-op (mode 3) and yields
// exactly one result beat with status, the removed pair (zero unless a removal
// succeeded) and the fill count after the operation. One operation is in flight
// at a time; the next beat is taken as soon as the current one has handed its
// result to the output register, even if that result is still waiting
// downstream. An insert walks up and a removal walks down at most
// floor(log2(CAPACITY)) heap levels, with one parent read per level going up
// and two child reads per level going down on the single read port of the heap
// RAM. No clearing pass runs after reset.
`timescale 1ns / 1ps
`include "binary_min_heap_queue_core_defines.svh"
module binary_min_heap_queue_core #(
  parameter int CAPACITY = bmhq_pkg::HeapCapacity
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [bmhq_pkg::InDataW-1:0]    in_tdata,   // key[15:0], payload[31:16]
  input  logic [bmhq_pkg::ModeW-1:0]      in_tuser,   // mode[1:0]
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [bmhq_pkg::OutDataW-1:0]   out_tdata,  // min_key[15:0], min_payload[31:16],
                                                      // count[38:32], zero[39]
  output logic [bmhq_pkg::StatusW-1:0]    out_tuser   // status[1:0]
);
  import bmhq_pkg::*;

  cmd_t cmd;
  sts_t sts;

  bmhq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_mode   (in_tuser),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  bmhq_dpath #(
    .CAPACITY (CAPACITY)
  ) u_dpath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  `BMHQ_ASSERT_NXT(a_busy_after_accept, in_tvalid && in_tready, !in_tready)
  `BMHQ_ASSERT_IMP(a_empty_result_zero, out_tvalid && out_tuser == ST_EMPTY,
                   out_tdata == '0)
  `BMHQ_ASSERT_IMP(a_full_result_no_pair, out_tvalid && out_tuser == ST_FULL,
                   out_tdata[31:0] == '0)
  `BMHQ_ASSERT_IMP(a_status_code, out_tvalid,
                   out_tuser == ST_OK || out_tuser == ST_FULL || out_tuser == ST_EMPTY)

endmodule

// ----- test/tb_top.sv -----
`timescale 1ns / 1ps
module tb_top;
  import bmhq_pkg::*;

  localparam logic [ModeW-1:0] MODE_UNUSED = 2'd3;
  localparam int ITEM_TARGET = 1700;
  localparam int TAIL_START = 1450;
  localparam int WATCHDOG_LIMIT = 2000;

  typedef struct packed {
    logic [StatusW-1:0]  status;
    logic [KeyW-1:0]     key;
    logic [PayloadW-1:0] payload;
    logic [CountW-1:0]   count;
  } heap_reply_t;

  class heap_scoreboard;
    logic [EntryW-1:0] slots [0:HeapCapacity];
    int fill;
    heap_reply_t pending_replies[$];
    int mismatches;
    int replies_checked;
    int full_refusals;
    int empty_refusals;

    function new();
      fill = 0;
      mismatches = 0;
      replies_checked = 0;
      full_refusals = 0;
      empty_refusals = 0;
    endfunction

    function void sift_in(logic [EntryW-1:0] entry);
      int pos;
      int up;
      pos = fill + 1;
      while (pos > 1) begin
        up = pos >> 1;
        if (entry[31:16] < slots[up][31:16]) begin
          slots[pos] = slots[up];
          pos = up;
        end else begin
          break;
        end
      end
      slots[pos] = entry;
      fill++;
    endfunction

    function logic [EntryW-1:0] take_root();
      logic [EntryW-1:0] root;
      logic [EntryW-1:0] last;
      int size;
      int pos;
      int left;
      int pick;
      root = slots[1];
      last = slots[fill];
      size = fill - 1;
      pos = 1;
      while (1) begin
        left = pos * 2;
        if (left > size) break;
        pick = left;
        if (left < size && slots[left][31:16] > slots[left+1][31:16]) pick = left + 1;
        if (last[31:16] <= slots[pick][31:16]) break;
        slots[pos] = slots[pick];
        pos = pick;
      end
      slots[pos] = last;
      fill = size;
      return root;
    endfunction

    function void note_command(logic [ModeW-1:0] mode, logic [KeyW-1:0] key,
                               logic [PayloadW-1:0] payload);
      heap_reply_t r;
      logic [EntryW-1:0] top;
      r = '0;
      case (mode)
        MODE_INSERT: begin
          if (fill >= HeapCapacity) begin
            r.status = ST_FULL;
            full_refusals++;
          end else begin
            sift_in({key, payload});
          end
        end
        MODE_REMOVE: begin
          if (fill == 0) begin
            r.status = ST_EMPTY;
            empty_refusals++;
          end else begin
            top = take_root();
            r.key = top[31:16];
            r.payload = top[15:0];
          end
        end
        MODE_CLEAR: fill = 0;
        default: ;
      endcase
      r.count = fill[CountW-1:0];
      pending_replies.push_back(r);
    endfunction

    function void compare_field(string name, int expected, int actual);
      if (expected != actual) begin
        $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, expected, actual);
        mismatches++;
      end
    endfunction

    function void check_reply(logic [StatusW-1:0] status, logic [OutDataW-1:0] data);
      heap_reply_t e;
      if (pending_replies.size() == 0) begin
        $display("%0t: unexpected result beat, actual status %0h data %0h",
                 $time, status, data);
        mismatches++;
        return;
      end
      e = pending_replies.pop_front();
      replies_checked++;
      compare_field("status", int'(e.status), int'(status));
      compare_field("min_key", int'(e.key), int'(data[15:0]));
      compare_field("min_payload", int'(e.payload), int'(data[31:16]));
      compare_field("count", int'(e.count), int'(data[38:32]));
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [InDataW-1:0] in_tdata = '0;
  logic [ModeW-1:0] in_tuser = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OutDataW-1:0] out_tdata;
  logic [StatusW-1:0] out_tuser;

  heap_scoreboard sb;
  int gap_pct = 0;
  int stall_pct = 0;
  int ready_hold = 0;
  int idle_cycles = 0;
  int items_done = 0;
  int phase = 0;
  int key_span = 0;
  int extra;

  binary_min_heap_queue_core u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_reply(out_tuser, out_tdata);
    if (ready_hold > 0) begin
      ready_hold--;
      out_tready <= 1'b0;
    end else if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
      ready_hold = $urandom_range(0, 5);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no beat moved for %0d cycles", $time, idle_cycles);
      $display("tb: failure");
      $finish;
    end
  end

  function automatic logic [KeyW-1:0] rand_word();
    return KeyW'($urandom_range(0, 65535));
  endfunction

  function automatic logic [KeyW-1:0] pick_key(int span);
    case (span)
      0: return rand_word();
      1: return KeyW'($urandom_range(0, 15));
      default: return ($urandom_range(0, 1) != 0) ? KeyW'(32'hFFFF - $urandom_range(0, 3))
                                                  : KeyW'($urandom_range(0, 3));
    endcase
  endfunction

  task automatic push_beat(input logic [ModeW-1:0] mode, input logic [KeyW-1:0] key,
                           input logic [PayloadW-1:0] payload);
    if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= mode;
    in_tdata <= {payload, key};
    do @(posedge clk); while (!in_tready);
    sb.note_command(mode, key, payload);
    if (mode != MODE_UNUSED) items_done++;
  endtask

  task automatic push_insert();
    push_beat(MODE_INSERT, pick_key(key_span), rand_word());
  endtask

  task automatic push_random_op();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) push_insert();
    else if (r < 93) push_beat(MODE_REMOVE, rand_word(), rand_word());
    else if (r < 96) push_beat(MODE_CLEAR, rand_word(), rand_word());
    else push_beat(MODE_UNUSED, rand_word(), rand_word());
  endtask

  initial begin
    sb = new();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    push_beat(MODE_REMOVE, 16'h0000, 16'h0000);
    push_beat(MODE_CLEAR, 16'h0000, 16'h0000);
    push_beat(MODE_UNUSED, 16'h0000, 16'h0000);
    push_beat(MODE_INSERT, 16'hFFFF, 16'h0000);
    push_beat(MODE_INSERT, 16'h0000, 16'hFFFF);
    push_beat(MODE_INSERT, 16'h8000, 16'hA5A5);
    push_beat(MODE_INSERT, 16'h8000, 16'h5A5A);
    push_beat(MODE_INSERT, 16'h0001, 16'h1234);
    push_beat(MODE_UNUSED, 16'hFFFF, 16'hFFFF);
    repeat (5) push_beat(MODE_REMOVE, 16'hFFFF, 16'hFFFF);
    push_beat(MODE_REMOVE, 16'h0000, 16'h0000);
    push_beat(MODE_INSERT, 16'h1234, 16'h0F0F);
    push_beat(MODE_INSERT, 16'h0F0F, 16'hF0F0);
    push_beat(MODE_CLEAR, 16'hFFFF, 16'hFFFF);
    push_beat(MODE_REMOVE, 16'h0000, 16'h0000);
    push_beat(MODE_INSERT, 16'hFFFF, 16'hFFFF);
    push_beat(MODE_REMOVE, 16'h0000, 16'h0000);

    while (items_done < ITEM_TARGET) begin
      if (items_done >= TAIL_START) begin
        gap_pct = 0;
        stall_pct = 0;
      end else begin
        gap_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 30);
        stall_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 30);
      end
      key_span = $urandom_range(0, 2);
      case (phase % 3)
        0: begin
          while (sb.fill < HeapCapacity) begin
            if ($urandom_range(0, 9) == 0)
              push_beat(MODE_REMOVE, rand_word(), rand_word());
            else push_insert();
          end
          extra = $urandom_range(1, 3);
          repeat (extra) push_insert();
        end
        1: begin
          while (sb.fill > 0) begin
            if ($urandom_range(0, 9) == 0) push_insert();
            else push_beat(MODE_REMOVE, rand_word(), rand_word());
          end
          extra = $urandom_range(1, 3);
          repeat (extra) push_beat(MODE_REMOVE, rand_word(), rand_word());
        end
        default: repeat (60) push_random_op();
      endcase
      phase++;
    end

    in_tvalid <= 1'b0;
    while (sb.pending_replies.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);

    $display("summary: %0d heap commands sent, %0d results checked, %0d mismatches",
             items_done, sb.replies_checked, sb.mismatches);
    $display("summary: %0d inserts refused at capacity, %0d removals refused when empty",
             sb.full_refusals, sb.empty_refusals);
    if (sb.mismatches == 0 && sb.pending_replies.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
